// ===== rtl/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial line editor package
// Shared constants, codes and types of the serial line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int unsigned DEF_LINE_DEPTH = 16;
    localparam int unsigned LIMIT_W        = 5;
    localparam int unsigned KIND_W         = 2;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_BRACKET = 8'h5B;
    localparam logic [7:0] CH_LEFT    = 8'h44;
    localparam logic [7:0] CH_RIGHT   = 8'h43;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SP      = 8'h20;

    typedef enum logic [KIND_W-1:0] {
        K_BYTE    = 2'd0,
        K_READ    = 2'd1,
        K_RELEASE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ESC_NONE    = 2'd0,
        ESC_SEEN    = 2'd1,
        ESC_BRACKET = 2'd2
    } t_esc;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CONST,
        S_RD,
        S_INS_RD,
        S_INS_WR,
        S_DBS,
        S_DEL_RD,
        S_DEL_WR,
        S_BS
    } t_state;

endpackage

// ===== rtl/sle_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sle_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/serial_line_editor.sv =====
// ----------------------------------------------------------------------------
// Serial line editor
// Builds one terminal line in a store with an edit cursor and echoes edits.
// ----------------------------------------------------------------------------
// The input stream carries one transaction per received byte, stored-byte
// read or line release; tuser selects the kind. The output stream returns
// echo bytes, read responses and release acknowledges, with tlast on the
// final result of each input transaction and the line status in tdata.
// The line lives in a RAM of LINE_DEPTH+1 bytes with a registered read.
// A plain byte, backspace at the end, CR/LF, a cursor move, a read and a
// release give their results from S_CONST or S_RD, one result per cycle
// while the receiver takes them. Mid-line insert or delete walks the tail
// one entry at a time (read, then write and echo) and then echoes the
// backspaces. An input that gives no result leaves the input ready in the
// next cycle. The input is taken only while no input transaction is being
// worked on. When the receiver stalls, the output register holds its
// transaction and the sequencer waits. Reset clears the line count,
// cursor, escape state and done flag and sets the limit to 16; the store
// itself is not cleared. The user writes the limit register through
// i_cfg_we only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module serial_line_editor #(
    parameter int unsigned LINE_DEPTH = sle_pkg::DEF_LINE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [15:0]                 i_s_tdata,  // rx_byte[7:0], read_index[11:8]
    input  logic [sle_pkg::KIND_W-1:0]  i_s_tuser,  // kind[1:0]
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [15:0]                 o_m_tdata,  // data[7:0], line_done[8], line_length[13:9]
    output logic                        o_m_tuser,  // is_read[0]
    output logic                        o_m_tlast,
    input  logic                        i_cfg_we,
    input  logic [sle_pkg::LIMIT_W-1:0] i_cfg_wdata
);

    import sle_pkg::*;

    localparam int unsigned CW = $clog2(LINE_DEPTH + 1);
    localparam logic [5:0]  DEPTH6 = 6'(LINE_DEPTH);

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_cursor, n_cursor;
    t_esc             r_esc, n_esc;
    logic             r_done, n_done;
    logic [LIMIT_W-1:0] r_limit;

    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_end, n_end;
    logic [CW-1:0]    r_bsn, n_bsn;
    logic [7:0]       r_carry, n_carry;
    logic [7:0]       r_cb [3];
    logic [7:0]       n_cb [3];
    logic [1:0]       r_cn, n_cn;
    logic [1:0]       r_ci, n_ci;
    logic             r_isrd, n_isrd;
    logic             r_zero, n_zero;

    logic             r_out_valid;
    logic [7:0]       r_out_data;
    logic             r_out_rd;
    logic             r_out_last;
    logic             r_out_done;
    logic [4:0]       r_out_len;

    logic             ram_we, ram_re;
    logic [CW-1:0]    ram_waddr, ram_raddr;
    logic [7:0]       ram_wdata, ram_rdata;

    logic             emit, e_last, e_rd, ok, accept, ignore;
    logic [7:0]       e_data, b;
    logic [3:0]       ridx;
    logic [5:0]       lim6;

    sle_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH + 1)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign ok         = !r_out_valid || i_m_tready;
    assign b          = i_s_tdata[7:0];
    assign ridx       = i_s_tdata[11:8];
    assign ignore     = r_done || (6'(r_count) >= DEPTH6);

    always_comb begin
        if (r_limit == '0) begin
            lim6 = 6'd1;
        end else if (6'(r_limit) > DEPTH6) begin
            lim6 = DEPTH6;
        end else begin
            lim6 = 6'(r_limit);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_esc    = r_esc;
        n_done   = r_done;
        n_idx    = r_idx;
        n_end    = r_end;
        n_bsn    = r_bsn;
        n_carry  = r_carry;
        n_cb     = r_cb;
        n_cn     = r_cn;
        n_ci     = r_ci;
        n_isrd   = r_isrd;
        n_zero   = r_zero;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = r_carry;
        ram_re    = 1'b0;
        ram_raddr = r_idx;
        emit   = 1'b0;
        e_data = '0;
        e_last = 1'b0;
        e_rd   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ci = 2'd0;
                    case (t_kind'(i_s_tuser))
                        K_BYTE: begin
                            if (!ignore) begin
                                if (r_esc == ESC_SEEN) begin
                                    n_esc = (b == CH_BRACKET) ? ESC_BRACKET : ESC_NONE;
                                end else if (r_esc == ESC_BRACKET) begin
                                    n_esc = ESC_NONE;
                                    if (b == CH_LEFT && r_cursor != '0) begin
                                        n_cursor = r_cursor - 1'b1;
                                        n_cb[0]  = CH_BS;
                                        n_cn     = 2'd1;
                                        n_state  = S_CONST;
                                    end else if (b == CH_RIGHT && r_cursor < r_count) begin
                                        ram_re    = 1'b1;
                                        ram_raddr = r_cursor;
                                        n_cursor  = r_cursor + 1'b1;
                                        n_isrd    = 1'b0;
                                        n_zero    = 1'b0;
                                        n_state   = S_RD;
                                    end
                                end else begin
                                    n_esc = ESC_NONE;
                                    if (b == CH_CR || b == CH_LF) begin
                                        n_cb[0]   = CH_CR;
                                        n_cb[1]   = CH_LF;
                                        n_cn      = 2'd2;
                                        ram_we    = 1'b1;
                                        ram_waddr = r_count;
                                        ram_wdata = CH_LF;
                                        n_done    = 1'b1;
                                        n_state   = S_CONST;
                                    end else if (b == CH_BS) begin
                                        if (r_cursor != '0) begin
                                            n_cursor = r_cursor - 1'b1;
                                            n_count  = r_count - 1'b1;
                                            if (r_cursor == r_count) begin
                                                n_cb[0] = CH_BS;
                                                n_cb[1] = CH_SP;
                                                n_cb[2] = CH_BS;
                                                n_cn    = 2'd3;
                                                n_state = S_CONST;
                                            end else begin
                                                n_idx   = r_cursor - 1'b1;
                                                n_end   = r_count;
                                                n_bsn   = r_count - r_cursor + 1'b1;
                                                n_state = S_DBS;
                                            end
                                        end
                                    end else if (b == CH_ESC) begin
                                        n_esc = ESC_SEEN;
                                    end else begin
                                        if (r_cursor < r_count) begin
                                            n_idx   = r_cursor;
                                            n_end   = r_count;
                                            n_carry = b;
                                            n_bsn   = r_count - r_cursor;
                                            n_state = S_INS_RD;
                                        end else begin
                                            ram_we    = 1'b1;
                                            ram_waddr = r_cursor;
                                            ram_wdata = b;
                                            n_cb[0]   = b;
                                            n_cn      = 2'd1;
                                            n_state   = S_CONST;
                                        end
                                        n_count  = r_count + 1'b1;
                                        n_cursor = r_cursor + 1'b1;
                                    end
                                end
                                if (6'(n_count) >= lim6) begin
                                    n_done = 1'b1;
                                end
                            end
                        end
                        K_READ: begin
                            ram_re    = 1'b1;
                            ram_raddr = CW'(ridx);
                            n_isrd    = 1'b1;
                            n_zero    = (6'(ridx) > DEPTH6);
                            n_state   = S_RD;
                        end
                        K_RELEASE: begin
                            if (r_done) begin
                                n_count  = '0;
                                n_cursor = '0;
                                n_esc    = ESC_NONE;
                                n_done   = 1'b0;
                            end
                            n_cb[0] = 8'h00;
                            n_cn    = 2'd1;
                            n_state = S_CONST;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CONST: begin
                if (ok) begin
                    emit   = 1'b1;
                    e_data = r_cb[r_ci];
                    e_last = (r_ci == r_cn - 2'd1);
                    n_ci   = r_ci + 2'd1;
                    if (e_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RD: begin
                if (ok) begin
                    emit    = 1'b1;
                    e_data  = r_zero ? 8'h00 : ram_rdata;
                    e_rd    = r_isrd;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_INS_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx;
                n_state   = S_INS_WR;
            end
            S_INS_WR: begin
                if (ok) begin
                    ram_we  = 1'b1;
                    emit    = 1'b1;
                    e_data  = r_carry;
                    n_carry = ram_rdata;
                    n_idx   = r_idx + 1'b1;
                    if (r_idx == r_end) begin
                        n_state = S_BS;
                    end else if (r_idx + 1'b1 < r_end) begin
                        n_state = S_INS_RD;
                    end else begin
                        n_state = S_INS_WR;
                    end
                end
            end
            S_DBS: begin
                if (ok) begin
                    emit    = 1'b1;
                    e_data  = CH_BS;
                    n_state = S_DEL_RD;
                end
            end
            S_DEL_RD: begin
                if (r_idx + 1'b1 < r_end) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx + 1'b1;
                end
                n_state = S_DEL_WR;
            end
            S_DEL_WR: begin
                if (ok) begin
                    ram_we    = 1'b1;
                    ram_wdata = (r_idx + 1'b1 < r_end) ? ram_rdata : CH_SP;
                    emit      = 1'b1;
                    e_data    = ram_wdata;
                    n_idx     = r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_end) begin
                        n_state = S_BS;
                    end else begin
                        n_state = S_DEL_RD;
                    end
                end
            end
            S_BS: begin
                if (ok) begin
                    emit   = 1'b1;
                    e_data = CH_BS;
                    e_last = (r_bsn == CW'(1));
                    n_bsn  = r_bsn - 1'b1;
                    if (e_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_esc       <= ESC_NONE;
            r_done      <= 1'b0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_esc    <= n_esc;
            r_done   <= n_done;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_end   <= n_end;
        r_bsn   <= n_bsn;
        r_carry <= n_carry;
        r_cb    <= n_cb;
        r_cn    <= n_cn;
        r_ci    <= n_ci;
        r_isrd  <= n_isrd;
        r_zero  <= n_zero;
        if (emit) begin
            r_out_data <= e_data;
            r_out_rd   <= e_rd;
            r_out_last <= e_last;
            r_out_done <= r_done;
            r_out_len  <= 5'(r_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_len, r_out_done, r_out_data};
    assign o_m_tuser  = r_out_rd;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== rtl/sle_checker.sv =====
// ----------------------------------------------------------------------------
// Serial line editor checker
// Port-level assertions on the serial line editor, attached by bind.
// ----------------------------------------------------------------------------
module sle_checker #(
    parameter int unsigned LINE_DEPTH = sle_pkg::DEF_LINE_DEPTH
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        o_s_tready,
    input logic [sle_pkg::KIND_W-1:0]  i_s_tuser,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [15:0]                 o_m_tdata,
    input logic                        o_m_tuser,
    input logic                        o_m_tlast
);

    import sle_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("Output transaction changed while stalled.");

    a_read_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("Read response is not a single transaction.");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> 32'(o_m_tdata[13:9]) <= LINE_DEPTH)
        else $error("Line length beyond the store depth.");

    a_busy_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == K_READ |=> !o_s_tready)
        else $error("Input accepted while a read is in progress.");

endmodule

bind serial_line_editor sle_checker #(.LINE_DEPTH(LINE_DEPTH)) u_sle_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial line editor testbench
// Drives received bytes, reads and releases into the editor and checks every
// echo, read response and release acknowledge against a line-edit predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import sle_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       is_read;
        logic       last;
        logic       done;
        logic [4:0] len;
    } t_echo;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_we;
    logic [4:0]  i_cfg_wdata;

    serial_line_editor i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    // Predicted editor state.
    logic [7:0] line_mem [0:16];
    bit         line_written [0:16];
    int unsigned n_chars, cursor;
    int unsigned esc_phase;
    bit          line_ready;
    logic [4:0]  limit_reg;

    t_echo echo_q [$];
    int    fail_count;
    int    items_sent;
    int    results_seen;
    int    lines_released;

    // Sender pacing and receiver stall pattern.
    bit          sender_bursty;
    int unsigned burst_left;
    int unsigned rx_mode;
    int unsigned hold_off;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("serial_line_editor: mismatch");
        $finish;
    end

    function automatic int unsigned eff_limit();
        if (limit_reg == 0) return 1;
        if (limit_reg > 16) return 16;
        return limit_reg;
    endfunction

    task automatic store_byte(int unsigned pos, logic [7:0] b);
        line_mem[pos] = b;
        line_written[pos] = 1'b1;
    endtask

    task automatic predict_editor(t_kind kind, logic [7:0] b, logic [3:0] idx);
        logic [7:0]  out [$];
        int unsigned tail;
        bit          rd;
        t_echo       e;
        rd = 1'b0;
        if (kind == K_BYTE) begin
            if (!line_ready && n_chars < 16) begin
                if (esc_phase == ESC_SEEN) begin
                    esc_phase = (b == CH_BRACKET) ? ESC_BRACKET : ESC_NONE;
                end else if (esc_phase == ESC_BRACKET) begin
                    if (b == CH_LEFT && cursor > 0) begin
                        cursor--;
                        out.push_back(CH_BS);
                    end else if (b == CH_RIGHT && cursor < n_chars) begin
                        out.push_back(line_mem[cursor]);
                        cursor++;
                    end
                    esc_phase = ESC_NONE;
                end else begin
                    esc_phase = ESC_NONE;
                    if (b == CH_CR || b == CH_LF) begin
                        out.push_back(CH_CR);
                        out.push_back(CH_LF);
                        store_byte(n_chars, CH_LF);
                        line_ready = 1'b1;
                    end else if (b == CH_BS) begin
                        if (cursor > 0 && cursor == n_chars) begin
                            out.push_back(CH_BS);
                            out.push_back(CH_SP);
                            out.push_back(CH_BS);
                            n_chars--;
                            cursor--;
                        end else if (cursor > 0) begin
                            cursor--;
                            for (int i = cursor; i + 1 < n_chars; i++)
                                store_byte(i, line_mem[i+1]);
                            store_byte(n_chars - 1, CH_SP);
                            out.push_back(CH_BS);
                            tail = n_chars - cursor;
                            for (int i = 0; i < tail; i++) out.push_back(line_mem[cursor+i]);
                            for (int i = 0; i < tail; i++) out.push_back(CH_BS);
                            n_chars--;
                        end
                    end else if (b == CH_ESC) begin
                        esc_phase = ESC_SEEN;
                    end else begin
                        tail = n_chars - cursor;
                        for (int i = n_chars; i > cursor; i--) store_byte(i, line_mem[i-1]);
                        store_byte(cursor, b);
                        for (int i = 0; i <= tail; i++) out.push_back(line_mem[cursor+i]);
                        for (int i = 0; i < tail; i++) out.push_back(CH_BS);
                        n_chars++;
                        cursor++;
                    end
                end
                if (n_chars >= eff_limit()) line_ready = 1'b1;
            end
        end else if (kind == K_READ) begin
            out.push_back(line_mem[idx]);
            rd = 1'b1;
        end else if (kind == K_RELEASE) begin
            if (line_ready) begin
                n_chars = 0;
                cursor = 0;
                esc_phase = ESC_NONE;
                line_ready = 1'b0;
                lines_released++;
            end
            out.push_back(8'h00);
        end
        foreach (out[k]) begin
            e.data = out[k];
            e.is_read = rd;
            e.last = (k == out.size() - 1);
            e.done = line_ready;
            e.len = n_chars[4:0];
            echo_q.push_back(e);
        end
    endtask

    task automatic send_item(t_kind kind, logic [7:0] b, logic [3:0] idx);
        int unsigned gap;
        gap = 0;
        if (sender_bursty) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                gap = $urandom_range(1, 12);
            end
            burst_left--;
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= kind;
        i_s_tdata <= {4'h0, idx, b};
        do @(posedge i_clk); while (!o_s_tready);
        predict_editor(kind, b, idx);
        items_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(K_BYTE, b, 4'($urandom_range(0, 15)));
    endtask

    task automatic send_read(logic [3:0] idx);
        send_item(K_READ, 8'($urandom_range(0, 255)), idx);
    endtask

    task automatic send_release();
        send_item(K_RELEASE, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (echo_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [4:0] value);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_reg = value;
    endtask

    task automatic random_read();
        int unsigned idx;
        idx = $urandom_range(0, 15);
        while (!line_written[idx]) idx = $urandom_range(0, 15);
        send_read(4'(idx));
    endtask

    task automatic random_item();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (line_ready && r < 55) begin
            send_release();
        end else if (r < 8) begin
            random_read();
        end else if (r < 11) begin
            send_release();
        end else if (r < 13) begin
            send_item(t_kind'(2'd3), 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
        end else if (r < 25) begin
            send_byte(CH_ESC);
            send_byte(CH_BRACKET);
            send_byte(($urandom_range(0, 1) != 0) ? CH_LEFT : CH_RIGHT);
        end else if (r < 38) begin
            send_byte(CH_BS);
        end else if (r < 42) begin
            send_byte(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
        end else if (r < 47) begin
            send_byte(CH_ESC);
            send_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) != 0) send_byte(8'($urandom_range(0, 255)));
        end else if (r < 55) begin
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_byte(8'($urandom_range(8'h21, 8'h7E)));
        end
    endtask

    task automatic test_directed();
        send_byte(8'h61);
        send_byte(8'h62);
        send_byte(CH_ESC); send_byte(CH_BRACKET); send_byte(CH_LEFT);
        send_byte(8'hFF);
        send_byte(CH_ESC); send_byte(CH_BRACKET); send_byte(CH_RIGHT);
        send_byte(CH_ESC); send_byte(CH_BRACKET); send_byte(CH_RIGHT);
        send_byte(CH_ESC); send_byte(CH_BRACKET); send_byte(CH_LEFT);
        send_byte(CH_ESC); send_byte(CH_BRACKET); send_byte(CH_LEFT);
        send_byte(CH_BS);
        send_byte(CH_ESC); send_byte(8'h41);
        send_byte(CH_ESC); send_byte(CH_BRACKET); send_byte(8'h5A);
        send_byte(CH_BS);
        send_byte(CH_BS);
        send_byte(CH_BS);
        send_byte(8'h00);
        send_read(4'd0);
        send_item(t_kind'(2'd3), 8'hA5, 4'hF);
        send_release();
        send_byte(CH_CR);
        send_byte(8'h7A);
        send_release();
        for (int i = 0; i < 16; i++) send_byte(8'(8'h41 + i));
        send_byte(8'h30);
        send_read(4'd15);
        send_release();
        send_byte(CH_LF);
        send_release();
    endtask

    task automatic test_limits();
        logic [4:0] lims [6];
        lims = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd16};
        foreach (lims[p]) begin
            write_limit(lims[p]);
            repeat (15) random_item();
        end
        write_limit(5'd10);
    endtask

    task automatic test_random_editing();
        for (int i = 0; i < 90; i++) begin
            if (i % 30 == 0) begin
                sender_bursty = (i != 60);
                rx_mode = (i / 30) % 3;
            end
            random_item();
        end
        rx_mode = 1;
        sender_bursty = 1'b1;
    endtask

    task automatic test_backpressure();
        sender_bursty = 1'b0;
        hold_off = 300;
        for (int i = 0; i < 20; i++) random_item();
        sender_bursty = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (10) random_item();
        drain_results();
        repeat (10) random_item();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off--;
            i_m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= ($urandom_range(0, 9) < 7);
                default: i_m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_echo e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (echo_q.size() == 0) begin
                $error("unexpected result transaction data=%h", o_m_tdata);
                fail_count++;
            end else begin
                e = echo_q.pop_front();
                if (o_m_tdata[7:0] !== e.data) begin
                    $error("data: expected %h, actual %h", e.data, o_m_tdata[7:0]);
                    fail_count++;
                end
                if (o_m_tuser !== e.is_read) begin
                    $error("is_read: expected %b, actual %b", e.is_read, o_m_tuser);
                    fail_count++;
                end
                if (o_m_tlast !== e.last) begin
                    $error("last: expected %b, actual %b", e.last, o_m_tlast);
                    fail_count++;
                end
                if (o_m_tdata[8] !== e.done) begin
                    $error("line_done: expected %b, actual %b", e.done, o_m_tdata[8]);
                    fail_count++;
                end
                if (o_m_tdata[13:9] !== e.len) begin
                    $error("line_length: expected %0d, actual %0d", e.len, o_m_tdata[13:9]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        n_chars = 0;
        cursor = 0;
        esc_phase = ESC_NONE;
        line_ready = 1'b0;
        limit_reg = LIMIT_RESET;
        foreach (line_mem[i]) begin
            line_mem[i] = 8'h00;
            line_written[i] = 1'b0;
        end
        fail_count = 0;
        items_sent = 0;
        results_seen = 0;
        lines_released = 0;
        sender_bursty = 1'b1;
        burst_left = 0;
        rx_mode = 1;
        hold_off = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_limits();
        test_random_editing();
        test_backpressure();
        test_drain_pause();
        drain_results();

        if (echo_q.size() != 0) begin
            $error("%0d expected results never arrived", echo_q.size());
            fail_count++;
        end
        $display("Sent %0d input transactions and checked %0d results.",
                 items_sent, results_seen);
        $display("Released %0d lines across seven limit settings.", lines_released);
        if (fail_count == 0) begin
            $display("serial_line_editor: match");
        end else begin
            $display("serial_line_editor: mismatch");
        end
        $finish;
    end
endmodule
